FILE: rtl/hcbe_pkg.sv
// shared constants, state codes and control types of the hill cipher block encoder
package hcbe_pkg;

    // configuration register map
    localparam int KEY_REGS  = 4;
    localparam int ENTRY_W   = 5;
    localparam int ROW_W     = KEY_REGS * ENTRY_W;
    localparam int CFG_IDX_W = 3;
    localparam int BSIZE_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_0  = 3'd1;

    localparam logic [BSIZE_W-1:0] BSIZE_RESET = 3'd2;

    // ascii letter bounds
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_RED_Q,
        ST_RED_R,
        ST_OUT
    } state_t;

    // sequencer to multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic acc_en;
        logic red_q_en;
        logic red_r_en;
    } mac_ctrl_t;

endpackage

FILE: rtl/hcbe_cfg_regs.sv
// configuration registers: block size and reduced key matrix with read port
module hcbe_cfg_regs
    import hcbe_pkg::*;
#(
    parameter int MAX_DIM  = 4,
    parameter int ALPHABET = 26,
    parameter int IDX_W    = 2,
    parameter int CNT_W    = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_wr_data,
    input  logic [IDX_W-1:0]     rd_row,
    input  logic [IDX_W-1:0]     rd_col,
    output logic [ENTRY_W-1:0]   rd_entry,
    output logic [CNT_W-1:0]     blk_len
);

    localparam int KDIM   = (MAX_DIM < KEY_REGS) ? MAX_DIM : KEY_REGS;
    localparam int KIDX_W = (KDIM > 1) ? $clog2(KDIM) : 1;

    logic [BSIZE_W-1:0] bsize_reg;
    logic [ENTRY_W-1:0] key_reg [KDIM][KDIM];
    logic [ENTRY_W-1:0] mod_tab [32];

    // residue table for five-bit values
    for (genvar g = 0; g < 32; g++) begin : g_mod
        assign mod_tab[g] = ENTRY_W'(g % ALPHABET);
    end

    // block size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bsize_reg <= BSIZE_RESET;
        end else if (cfg_wr_en && cfg_index == CFG_BLOCK_SIZE) begin
            bsize_reg <= cfg_wr_data[BSIZE_W-1:0];
        end
    end

    // key rows, each entry reduced as it is written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < KDIM; r++) begin
                for (int c = 0; c < KDIM; c++) begin
                    key_reg[r][c] <= '0;
                end
            end
        end else if (cfg_wr_en) begin
            for (int r = 0; r < KDIM; r++) begin
                if (cfg_index == CFG_IDX_W'(int'(CFG_KEY_ROW_0) + r)) begin
                    for (int c = 0; c < KDIM; c++) begin
                        key_reg[r][c] <= mod_tab[cfg_wr_data[ENTRY_W*c +: ENTRY_W]];
                    end
                end
            end
        end
    end

    // key read, rows and columns past the stored ones read as zero
    always_comb begin
        if (int'(rd_row) < KDIM && int'(rd_col) < KDIM) begin
            rd_entry = key_reg[rd_row[KIDX_W-1:0]][rd_col[KIDX_W-1:0]];
        end else begin
            rd_entry = '0;
        end
    end

    // effective block length, clamped to one..MAX_DIM
    always_comb begin
        if (bsize_reg == '0) begin
            blk_len = CNT_W'(1);
        end else if (int'(bsize_reg) > MAX_DIM) begin
            blk_len = CNT_W'(MAX_DIM);
        end else begin
            blk_len = CNT_W'(bsize_reg);
        end
    end

endmodule

FILE: rtl/hcbe_mac.sv
// shared multiply-accumulate unit with reciprocal residue reduction
module hcbe_mac
    import hcbe_pkg::*;
#(
    parameter int MAX_DIM  = 4,
    parameter int ALPHABET = 26
) (
    input  logic               aclk,
    input  mac_ctrl_t          ctrl,
    input  logic [ENTRY_W-1:0] key_val,
    input  logic [ENTRY_W-1:0] letter_val,
    output logic [ENTRY_W-1:0] result
);

    localparam int SUM_W  = $clog2(MAX_DIM * (ALPHABET - 1) * (ALPHABET - 1) + 1);
    localparam int RECIP  = (1 << SUM_W) / ALPHABET;
    localparam int CALC_W = SUM_W + 6;

    localparam logic [SUM_W-1:0]  RECIP_C = SUM_W'(RECIP);
    localparam logic [CALC_W-1:0] ALPH_C  = CALC_W'(ALPHABET);

    logic [2*ENTRY_W-1:0] prod;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [2*SUM_W-1:0]   qprod;
    logic [SUM_W-1:0]     q_reg;
    logic [CALC_W-1:0]    rem_raw, rem_fix;
    logic [ENTRY_W-1:0]   res_reg;

    // one product per cycle into the running sum while acc_en is set
    assign prod     = key_val * letter_val;
    assign sum_next = ctrl.clear ? SUM_W'(prod) : SUM_W'(sum_reg + SUM_W'(prod));

    // quotient estimate, low by at most one
    assign qprod = sum_reg * RECIP_C;

    // remainder with a single correction step
    assign rem_raw = CALC_W'(sum_reg) - CALC_W'(q_reg) * ALPH_C;
    assign rem_fix = (rem_raw >= ALPH_C) ? (rem_raw - ALPH_C) : rem_raw;

    always_ff @(posedge aclk) begin
        if (ctrl.acc_en) begin
            sum_reg <= sum_next;
        end
        if (ctrl.red_q_en) begin
            q_reg <= qprod[2*SUM_W-1:SUM_W];
        end
        if (ctrl.red_r_en) begin
            res_reg <= rem_fix[ENTRY_W-1:0];
        end
    end

    assign result = res_reg;

endmodule

FILE: rtl/hill_cipher_block_encoder.sv
// hill cipher block encoder: letter buffer, sequencer and result port
// a letter that does not close a block is stored in the buffer while idle
// a closing letter starts the block: each of the n results accumulates n products,
// then passes the two reduction states and one output beat, which waits for m_ready
// one shared multiplier; no letter is taken until the block's last result is taken
// reset: block size 2, key all zero, fill count zero; the letter buffer is not cleared
module hill_cipher_block_encoder
    import hcbe_pkg::*;
#(
    parameter int MAX_DIM  = 4,
    parameter int ALPHABET = 26
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_char_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [6:0]           m_cipher_char,
    output logic                 m_last_of_block
);

    localparam int FW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W = FW + 1;

    state_t             state_reg, state_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [FW-1:0]      row_reg, row_next;
    logic [FW-1:0]      col_reg, col_next;
    logic [ENTRY_W-1:0] letter_buf [MAX_DIM];
    logic [ENTRY_W-1:0] mod_tab [32];
    logic [ENTRY_W-1:0] lv_raw, lv;
    logic [CNT_W-1:0]   blk_len;
    logic [CNT_W-1:0]   count_inc;
    logic [ENTRY_W-1:0] key_val;
    logic [ENTRY_W-1:0] mac_result;
    logic [7:0]         char_wide;
    logic               buf_we;
    logic               col_last;
    logic               row_last;
    mac_ctrl_t          ctrl;

    // configuration registers
    hcbe_cfg_regs #(
        .MAX_DIM  (MAX_DIM),
        .ALPHABET (ALPHABET),
        .IDX_W    (FW),
        .CNT_W    (CNT_W)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .rd_row      (row_reg),
        .rd_col      (col_reg),
        .rd_entry    (key_val),
        .blk_len     (blk_len)
    );

    // shared multiply-accumulate
    hcbe_mac #(
        .MAX_DIM  (MAX_DIM),
        .ALPHABET (ALPHABET)
    ) u_mac (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .key_val    (key_val),
        .letter_val (letter_buf[col_reg]),
        .result     (mac_result)
    );

    // residue table for letter values
    for (genvar g = 0; g < 32; g++) begin : g_mod
        assign mod_tab[g] = ENTRY_W'(g % ALPHABET);
    end

    // byte to letter value
    always_comb begin
        if (s_char_in >= ASCII_LOWER_A && s_char_in <= ASCII_LOWER_Z) begin
            lv_raw = ENTRY_W'(s_char_in - ASCII_LOWER_A);
        end else if (s_char_in >= ASCII_UPPER_A && s_char_in <= ASCII_UPPER_Z) begin
            lv_raw = ENTRY_W'(s_char_in - ASCII_UPPER_A);
        end else begin
            lv_raw = '0;
        end
    end

    assign lv = mod_tab[lv_raw];

    assign count_inc = CNT_W'(fill_reg) + CNT_W'(1);
    assign col_last  = (CNT_W'(col_reg) + CNT_W'(1)) == blk_len;
    assign row_last  = (CNT_W'(row_reg) + CNT_W'(1)) == blk_len;

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // letter buffer write
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            letter_buf[fill_reg] <= lv;
        end
    end

    // sequencer: collect letters, then one row dot product per result
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        ctrl       = '0;
        buf_we     = 1'b0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    buf_we = 1'b1;
                    if (count_inc >= blk_len) begin
                        fill_next  = '0;
                        row_next   = '0;
                        col_next   = '0;
                        state_next = ST_MAC;
                    end else begin
                        fill_next = count_inc[FW-1:0];
                    end
                end
            end
            ST_MAC: begin
                ctrl.acc_en = 1'b1;
                ctrl.clear  = (col_reg == '0);
                if (col_last) begin
                    col_next   = '0;
                    state_next = ST_RED_Q;
                end else begin
                    col_next = col_reg + FW'(1);
                end
            end
            ST_RED_Q: begin
                ctrl.red_q_en = 1'b1;
                state_next    = ST_RED_R;
            end
            ST_RED_R: begin
                ctrl.red_r_en = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (row_last) begin
                        row_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        row_next   = row_reg + FW'(1);
                        state_next = ST_MAC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result beat
    assign char_wide       = ASCII_LOWER_A + {3'b000, mac_result};
    assign m_cipher_char   = char_wide[6:0];
    assign m_last_of_block = row_last;

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channel active together");

    a_block_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_of_block) |=> s_ready)
        else $error("no return to idle after last beat of block");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) < MAX_DIM)
        else $error("fill count out of range");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (CNT_W'(row_reg) < blk_len))
        else $error("result row past block length");

    a_reduce_after_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RED_Q) |-> $past(state_reg == ST_MAC))
        else $error("reduction started without accumulation");

endmodule

FILE: bench/hill_cipher_block_encoder_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the hill cipher block encoder: directed text, then random phases
module hill_cipher_block_encoder_test;
    import hcbe_pkg::*;

    localparam int DIM           = 4;
    localparam int MOD           = 26;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 28;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(CFG_KEY_ROW_0 + KEY_REGS);

    typedef struct {
        logic [7:0]  ch;
        int unsigned idle;
    } text_beat_t;

    typedef struct {
        logic [6:0] letter;
        logic       last_flag;
    } cipher_beat_t;

    logic                 aclk;
    logic                 aresetn         = 1'b0;
    logic                 cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [ROW_W-1:0]     cfg_wr_data     = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_char_in       = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [6:0]           m_cipher_char;
    logic                 m_last_of_block;

    // expected cipher letters and pending text beats
    cipher_beat_t cipher_expect[$];
    text_beat_t   text_queue[$];

    // encoder mirror: key, block size and partial block
    logic [4:0]  key_mat [DIM][DIM];
    logic [2:0]  bsize_reg;
    logic [4:0]  letters [DIM];
    int unsigned letters_held;

    // handshake bookkeeping
    logic        s_fire = 1'b0;
    logic        m_fire = 1'b0;
    text_beat_t  cur;
    bit          cur_loaded   = 1'b0;
    int unsigned tx_idle_left = 0;
    int unsigned rx_idle_left = 0;
    bit          tx_quiet     = 1'b0;
    bit          rx_quiet     = 1'b0;

    int fail_count     = 0;
    int letters_sent   = 0;
    int results_checked = 0;
    int writes_done    = 0;

    hill_cipher_block_encoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_in       (s_char_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cipher_char   (m_cipher_char),
        .m_last_of_block (m_last_of_block)
    );

    // letters of either case give 0..25, anything else gives 0
    function automatic logic [4:0] letter_code(logic [7:0] b);
        if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
            return 5'(b - ASCII_LOWER_A);
        end
        if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
            return 5'(b - ASCII_UPPER_A);
        end
        return '0;
    endfunction

    // block size zero acts as one, above four saturates
    function automatic int unsigned block_len();
        int unsigned n;
        n = bsize_reg;
        if (n < 1) n = 1;
        if (n > DIM) n = DIM;
        return n;
    endfunction

    // take one character; a full block yields n cipher letters
    function automatic void encode_letter(logic [7:0] ch);
        int unsigned  n;
        int unsigned  acc;
        cipher_beat_t beat;
        n = block_len();
        if (letters_held >= DIM) letters_held = 0;
        letters[letters_held] = letter_code(ch);
        letters_held++;
        if (letters_held >= n) begin
            for (int i = 0; i < n; i++) begin
                acc = 0;
                for (int j = 0; j < n; j++) begin
                    acc += key_mat[i][j] * letters[j];
                end
                beat.letter    = 7'(ASCII_LOWER_A + acc % MOD);
                beat.last_flag = (i == n - 1);
                cipher_expect.push_back(beat);
            end
            letters_held = 0;
        end
    endfunction

    // register write as seen by the mirror; unused indexes do nothing
    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        int row;
        if (idx == CFG_BLOCK_SIZE) begin
            bsize_reg = data[BSIZE_W-1:0];
        end else if (idx >= CFG_KEY_ROW_0 && idx < CFG_FIRST_UNUSED) begin
            row = int'(idx - CFG_KEY_ROW_0);
            for (int j = 0; j < KEY_REGS; j++) begin
                key_mat[row][j] = ENTRY_W'(data[j*ENTRY_W +: ENTRY_W] % MOD);
            end
        end
    endfunction

    function automatic logic [ROW_W-1:0] pack_row(int e0, int e1, int e2, int e3);
        return {ENTRY_W'(e3), ENTRY_W'(e2), ENTRY_W'(e1), ENTRY_W'(e0)};
    endfunction

    function automatic int unsigned pick_idle(bit quiet);
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        apply_setting(idx, data);
        writes_done++;
    endtask

    task automatic push_char(input logic [7:0] ch);
        text_beat_t beat;
        beat.ch   = ch;
        beat.idle = pick_idle(tx_quiet);
        text_queue.push_back(beat);
    endtask

    // sender holds off until all text is taken and every cipher letter is back
    task automatic wait_drained();
        while (text_queue.size() != 0 || cur_loaded || s_valid || cipher_expect.size() != 0) begin
            @(negedge aclk);
        end
        // a letter that closes no block may still be in flight
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // text driver: idle gap per beat, then valid held until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_char_in  <= '0;
            cur_loaded = 1'b0;
        end else if (!s_valid || s_fire) begin
            if (s_fire) cur_loaded = 1'b0;
            if (!cur_loaded && text_queue.size() != 0) begin
                cur          = text_queue.pop_front();
                cur_loaded   = 1'b1;
                tx_idle_left = cur.idle;
            end
            if (cur_loaded && tx_idle_left == 0) begin
                s_valid   <= 1'b1;
                s_char_in <= cur.ch;
            end else begin
                s_valid <= 1'b0;
                if (cur_loaded) tx_idle_left--;
            end
        end
    end

    // result side back-pressure: a stall drawn after every beat
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            rx_idle_left = 0;
        end else begin
            if (m_fire) rx_idle_left = pick_idle(rx_quiet);
            if (rx_idle_left != 0) begin
                m_ready <= 1'b0;
                rx_idle_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: check result beats, feed accepted text to the mirror
    always @(posedge aclk) begin
        cipher_beat_t want;
        s_fire <= aresetn && s_valid && s_ready;
        m_fire <= aresetn && m_valid && m_ready;
        if (aresetn && m_valid && m_ready) begin
            if (cipher_expect.size() == 0) begin
                $error("unexpected beat: cipher_char %0h last_of_block %0b",
                       m_cipher_char, m_last_of_block);
                fail_count++;
            end else begin
                want = cipher_expect.pop_front();
                if (m_cipher_char !== want.letter) begin
                    $error("cipher_char expected %0h actual %0h", want.letter, m_cipher_char);
                    fail_count++;
                end
                if (m_last_of_block !== want.last_flag) begin
                    $error("last_of_block expected %0b actual %0b",
                           want.last_flag, m_last_of_block);
                    fail_count++;
                end
                results_checked++;
            end
        end
        if (aresetn && s_valid && s_ready) begin
            encode_letter(s_char_in);
            letters_sent++;
        end
    end

    // stimulus and end of run
    initial begin
        logic [ROW_W-1:0] setting;
        logic [2:0]       size;
        logic [7:0]       ch;
        int unsigned      pick;

        for (int r = 0; r < DIM; r++) begin
            letters[r] = '0;
            for (int c = 0; c < DIM; c++) key_mat[r][c] = '0;
        end
        bsize_reg    = BSIZE_RESET;
        letters_held = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset key is all zero, block of two
        @(posedge aclk);
        push_char("a");
        push_char("b");
        wait_drained();

        // key entries at 0, 25, 26 and 31, block of four, letter bounds
        write_reg(CFG_KEY_ROW_0, pack_row(31, 0, 0, 0));
        write_reg(CFG_IDX_W'(CFG_KEY_ROW_0 + 1), pack_row(0, 26, 0, 25));
        write_reg(CFG_IDX_W'(CFG_KEY_ROW_0 + 2), pack_row(25, 25, 25, 25));
        write_reg(CFG_IDX_W'(CFG_KEY_ROW_0 + 3), pack_row(1, 2, 3, 4));
        write_reg(CFG_BLOCK_SIZE, ROW_W'(4));
        @(posedge aclk);
        push_char("a");
        push_char("z");
        push_char("A");
        push_char("Z");
        push_char(8'h40);
        push_char(8'h5b);
        push_char(8'h60);
        push_char(8'h7b);
        push_char(8'h00);
        push_char(8'hff);
        push_char(8'he1);
        push_char(8'h7a);
        wait_drained();

        // writes past the key rows change nothing; block size zero acts as one
        write_reg(CFG_FIRST_UNUSED, '1);
        write_reg(CFG_IDX_W'(CFG_FIRST_UNUSED + 1), '1);
        write_reg(CFG_IDX_W'(CFG_FIRST_UNUSED + 2), '1);
        write_reg(CFG_BLOCK_SIZE, ROW_W'(0));
        @(posedge aclk);
        push_char("m");
        push_char("Q");
        wait_drained();

        // size seven saturates to four, then shrinks to two with three letters held
        write_reg(CFG_BLOCK_SIZE, '1);
        @(posedge aclk);
        push_char("h");
        push_char("i");
        push_char("l");
        wait_drained();
        write_reg(CFG_BLOCK_SIZE, ROW_W'(2));
        @(posedge aclk);
        push_char("l");
        wait_drained();

        // size grows from two to three with one letter held
        @(posedge aclk);
        push_char("c");
        wait_drained();
        write_reg(CFG_BLOCK_SIZE, ROW_W'(3));
        @(posedge aclk);
        push_char("i");
        push_char("p");

        // random phases, each with its own key, size and idling mix
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            tx_quiet = (p == 5) || (p == 6);
            rx_quiet = (p == 5) || (p == 7);
            case (p)
                0: size = 3'd1;
                1: size = 3'd4;
                2: size = 3'd0;
                3: size = 3'd7;
                default: size = 3'($urandom_range(0, 7));
            endcase
            setting = ROW_W'($urandom);
            setting[BSIZE_W-1:0] = size;
            write_reg(CFG_BLOCK_SIZE, setting);
            for (int r = 0; r < KEY_REGS; r++) begin
                case (p)
                    2: setting = '1;
                    3: setting = pack_row(25, 25, 25, 25);
                    4: setting = '0;
                    default: setting = ROW_W'($urandom);
                endcase
                write_reg(CFG_IDX_W'(CFG_KEY_ROW_0 + r), setting);
            end
            @(posedge aclk);
            // mostly letters, some arbitrary bytes
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    ch = 8'(ASCII_LOWER_A + $urandom_range(0, 25));
                end else if (pick < 8) begin
                    ch = 8'(ASCII_UPPER_A + $urandom_range(0, 25));
                end else begin
                    ch = 8'($urandom_range(0, 255));
                end
                push_char(ch);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("text beats sent %0d, cipher beats checked %0d, register writes %0d",
                 letters_sent, results_checked, writes_done);
        $display("block sizes 0..7 incl. mid-block changes, key entries 0..31, unused indexes");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: hill_cipher_block_encoder.f
rtl/hcbe_pkg.sv
rtl/hcbe_cfg_regs.sv
rtl/hcbe_mac.sv
rtl/hill_cipher_block_encoder.sv
bench/hill_cipher_block_encoder_test.sv
